// ----- hdl/bloom_filter_insert_query_defines.svh -----
// assertion helpers for the bloom filter block
`ifndef BLOOM_FILTER_INSERT_QUERY_DEFINES_SVH
`define BLOOM_FILTER_INSERT_QUERY_DEFINES_SVH

// implication checked on every edge outside reset
`define BFIQ_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BFIQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/bfiq_pkg.sv -----
package bfiq_pkg;

  localparam logic [31:0] HashSeed = 32'hbc9f1d34;
  localparam logic [31:0] MixC1    = 32'hcc9e2d51;
  localparam logic [31:0] MixC2    = 32'h1b873593;
  localparam logic [31:0] FinC1    = 32'h85ebca6b;
  localparam logic [31:0] FinC2    = 32'hc2b2ae35;
  localparam logic [31:0] RoundAdd = 32'he6546b64;

  localparam logic CmdInsert = 1'b0;
  localparam logic CmdQuery  = 1'b1;

  localparam logic RegBitCount   = 1'b0;
  localparam logic RegProbeCount = 1'b1;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MIX1,
    ST_MIX2,
    ST_FIN1,
    ST_FIN2,
    ST_FIN3,
    ST_FIN4,
    ST_MOD,
    ST_PROBE,
    ST_WAIT,
    ST_RESULT
  } state_e;

  // hash datapath operations
  typedef enum logic [3:0] {
    OP_NONE,
    OP_BYTE,
    OP_MIX1,
    OP_MIX2,
    OP_ROUND,
    OP_FIN1,
    OP_FIN2,
    OP_FIN3,
    OP_FIN4,
    OP_START,
    OP_STEP
  } hop_e;

  typedef struct packed {
    hop_e op;
    logic mod_start;
    logic mem_rd;
    logic mem_wr;
    logic clr_wr;
    logic hash_clear;
    logic res_clear;
    logic res_check;
  } cmd_t;

  typedef struct packed {
    logic mod_done;
    logic clr_last;
    logic tail_pending;
    logic round_due;
  } stat_t;

endpackage

// ----- hdl/bfiq_ram.sv -----
module bfiq_ram #(
  parameter int Width = 1,
  parameter int Depth = 65536
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

// ----- hdl/bfiq_mod.sv -----
// restoring remainder, one quotient bit per cycle
module bfiq_mod #(
  parameter int DivW = 17
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [31:0]     dividend_i,
  input  logic [DivW-1:0] divisor_i,
  output logic            done_o,
  output logic [DivW-1:0] rem_o
);

  logic [31:0]   quo_q, quo_d;
  logic [DivW:0] rem_q, rem_d;
  logic [5:0]    cnt_q, cnt_d;
  logic          busy_q, busy_d;
  logic [DivW:0] trial;

  always_comb begin
    trial  = {rem_q[DivW-1:0], quo_q[31]};
    quo_d  = quo_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_o = 1'b0;
    if (start_i) begin
      quo_d  = dividend_i;
      rem_d  = '0;
      cnt_d  = 6'd32;
      busy_d = 1'b1;
    end else if (busy_q) begin
      quo_d = {quo_q[30:0], 1'b0};
      if (trial >= {1'b0, divisor_i}) begin
        rem_d = trial - {1'b0, divisor_i};
      end else begin
        rem_d = trial;
      end
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) begin
        busy_d = 1'b0;
        done_o = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
  end

  assign rem_o = rem_d[DivW-1:0];

endmodule

// ----- hdl/bfiq_datapath.sv -----
module bfiq_datapath #(
  parameter int MaxFilterBits = 65536,
  parameter int MaxProbes     = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  bfiq_pkg::cmd_t       cmd_i,
  output bfiq_pkg::stat_t      stat_o,
  input  logic [7:0]           byte_i,
  input  logic                 is_query_i,
  input  logic [16:0]          bit_count_i,
  input  logic [5:0]           probe_count_i,
  output logic                 probe_last_o,
  output logic                 all_set_o
);

  localparam int AddrW = $clog2(MaxFilterBits);
  localparam int DivW  = $clog2(MaxFilterBits + 1);
  localparam int PrbW  = $clog2(MaxProbes + 1);

  logic [31:0] hash_q, hash_d;
  logic [31:0] acc_q, acc_d;
  logic [1:0]  fill_q, fill_d;
  logic [31:0] len_q, len_d;
  logic [31:0] work_q, work_d;
  logic [31:0] step_q, step_d;
  logic [PrbW-1:0] prb_q, prb_d;
  logic [AddrW-1:0] clr_q, clr_d;
  logic        ok_q, ok_d;
  logic [AddrW-1:0] pos_q;
  logic [DivW-1:0] bc_sat, rem;
  logic [PrbW-1:0] np_sat;
  logic        mod_done;
  logic        rd_bit;
  logic [31:0] kx, hx;

  // saturated register values
  always_comb begin
    if (bit_count_i == 17'd0) begin
      bc_sat = DivW'(1);
    end else if (32'(bit_count_i) > 32'(MaxFilterBits)) begin
      bc_sat = DivW'(MaxFilterBits);
    end else begin
      bc_sat = DivW'(bit_count_i);
    end
    if (probe_count_i == 6'd0) begin
      np_sat = PrbW'(1);
    end else if (32'(probe_count_i) > 32'(MaxProbes)) begin
      np_sat = PrbW'(MaxProbes);
    end else begin
      np_sat = PrbW'(probe_count_i);
    end
  end

  always_comb begin
    hash_d = hash_q;
    acc_d  = acc_q;
    fill_d = fill_q;
    len_d  = len_q;
    work_d = work_q;
    step_d = step_q;
    prb_d  = prb_q;
    kx     = '0;
    hx     = '0;
    case (cmd_i.op)
      bfiq_pkg::OP_BYTE: begin
        acc_d  = acc_q | (32'(byte_i) << {fill_q, 3'b000});
        fill_d = fill_q + 2'd1;
        len_d  = len_q + 32'd1;
      end
      bfiq_pkg::OP_MIX1: begin
        work_d = acc_q * bfiq_pkg::MixC1;
      end
      bfiq_pkg::OP_MIX2: begin
        kx     = {work_q[16:0], work_q[31:17]};
        work_d = kx * bfiq_pkg::MixC2;
      end
      bfiq_pkg::OP_ROUND: begin
        kx     = hash_q ^ work_q;
        hx     = {kx[18:0], kx[31:19]};
        hash_d = (hx << 2) + hx + bfiq_pkg::RoundAdd;
        acc_d  = '0;
      end
      bfiq_pkg::OP_FIN1: begin
        kx     = (fill_q != 2'd0) ? (hash_q ^ work_q) : hash_q;
        kx     = kx ^ len_q;
        hx     = kx ^ (kx >> 16);
        work_d = hx * bfiq_pkg::FinC1;
      end
      bfiq_pkg::OP_FIN2: begin
        hx     = work_q ^ (work_q >> 13);
        work_d = hx * bfiq_pkg::FinC2;
      end
      bfiq_pkg::OP_FIN3: begin
        work_d = work_q ^ (work_q >> 16);
      end
      bfiq_pkg::OP_FIN4: begin
        step_d = {work_q[16:0], work_q[31:17]};
        prb_d  = '0;
      end
      bfiq_pkg::OP_STEP: begin
        work_d = work_q + step_q;
        prb_d  = prb_q + PrbW'(1);
      end
      default: begin
      end
    endcase
    if (cmd_i.hash_clear) begin
      hash_d = bfiq_pkg::HashSeed;
      acc_d  = '0;
      fill_d = '0;
      len_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hash_q <= bfiq_pkg::HashSeed;
      acc_q  <= '0;
      fill_q <= '0;
      len_q  <= '0;
      clr_q  <= '0;
      ok_q   <= 1'b1;
      prb_q  <= '0;
    end else begin
      hash_q <= hash_d;
      acc_q  <= acc_d;
      fill_q <= fill_d;
      len_q  <= len_d;
      clr_q  <= clr_d;
      ok_q   <= ok_d;
      prb_q  <= prb_d;
    end
  end

  always_ff @(posedge clk_i) begin
    work_q <= work_d;
    step_q <= step_d;
    if (mod_done) begin
      pos_q <= rem[AddrW-1:0];
    end
  end

  assign clr_d = cmd_i.clr_wr ? clr_q + AddrW'(1) : clr_q;

  always_comb begin
    ok_d = ok_q;
    if (cmd_i.res_clear) begin
      ok_d = 1'b1;
    end else if (cmd_i.res_check && !rd_bit) begin
      ok_d = 1'b0;
    end
  end

  // the divider takes the advanced hash in the same cycle as the step
  bfiq_mod #(.DivW(DivW)) u_mod (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (cmd_i.mod_start),
    .dividend_i(work_d),
    .divisor_i (bc_sat),
    .done_o    (mod_done),
    .rem_o     (rem)
  );

  bfiq_ram #(.Width(1), .Depth(MaxFilterBits)) u_ram (
    .clk_i  (clk_i),
    .we_i   (cmd_i.mem_wr || cmd_i.clr_wr),
    .waddr_i(cmd_i.clr_wr ? clr_q : pos_q),
    .wdata_i(cmd_i.clr_wr ? 1'b0 : 1'b1),
    .re_i   (cmd_i.mem_rd),
    .raddr_i(pos_q),
    .rdata_o(rd_bit)
  );

  assign stat_o.mod_done     = mod_done;
  assign stat_o.clr_last     = (clr_q == AddrW'(MaxFilterBits - 1));
  assign stat_o.tail_pending = (fill_q != 2'd0);
  assign stat_o.round_due    = (fill_q == 2'd3);
  assign probe_last_o = (prb_q == np_sat - PrbW'(1));
  assign all_set_o    = (is_query_i == bfiq_pkg::CmdQuery) ? ok_d : 1'b1;

endmodule

// ----- hdl/bfiq_ctrl.sv -----
`include "bloom_filter_insert_query_defines.svh"

module bfiq_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic            has_byte_i,
  input  logic            last_byte_i,
  input  logic            cmd_i,
  output logic            out_valid_o,
  input  logic            out_ready_o_i,
  output bfiq_pkg::cmd_t  dp_o,
  input  bfiq_pkg::stat_t st_i,
  input  logic            probe_last_i,
  output logic            is_query_o,
  output logic            res_load_o
);

  bfiq_pkg::state_e state_q, state_d;
  logic qry_q, qry_d;
  logic last_q, last_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bfiq_pkg::ST_CLEAR;
      qry_q   <= 1'b0;
      last_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      qry_q   <= qry_d;
      last_q  <= last_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    qry_d       = qry_q;
    last_d      = last_q;
    dp_o        = '0;
    dp_o.op     = bfiq_pkg::OP_NONE;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    res_load_o  = 1'b0;
    case (state_q)
      bfiq_pkg::ST_CLEAR: begin
        dp_o.clr_wr = 1'b1;
        if (st_i.clr_last) begin
          state_d = bfiq_pkg::ST_IDLE;
        end
      end
      bfiq_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          qry_d  = cmd_i;
          last_d = last_byte_i;
          if (has_byte_i) begin
            dp_o.op = bfiq_pkg::OP_BYTE;
            if (st_i.round_due) begin
              state_d = bfiq_pkg::ST_MIX1;
            end else if (last_byte_i) begin
              state_d = bfiq_pkg::ST_MIX1;
            end
          end else if (last_byte_i) begin
            state_d = st_i.tail_pending ? bfiq_pkg::ST_MIX1 : bfiq_pkg::ST_FIN1;
          end
        end
      end
      bfiq_pkg::ST_MIX1: begin
        dp_o.op = bfiq_pkg::OP_MIX1;
        state_d = bfiq_pkg::ST_MIX2;
      end
      bfiq_pkg::ST_MIX2: begin
        dp_o.op = bfiq_pkg::OP_MIX2;
        // a full block folds in through the wait state, a partial one waits for the finish
        state_d = st_i.tail_pending ? bfiq_pkg::ST_FIN1 : bfiq_pkg::ST_WAIT;
      end
      bfiq_pkg::ST_WAIT: begin
        dp_o.op = bfiq_pkg::OP_ROUND;
        state_d = last_q ? bfiq_pkg::ST_FIN1 : bfiq_pkg::ST_IDLE;
      end
      bfiq_pkg::ST_FIN1: begin
        dp_o.op = bfiq_pkg::OP_FIN1;
        state_d = bfiq_pkg::ST_FIN2;
      end
      bfiq_pkg::ST_FIN2: begin
        dp_o.op = bfiq_pkg::OP_FIN2;
        state_d = bfiq_pkg::ST_FIN3;
      end
      bfiq_pkg::ST_FIN3: begin
        dp_o.op         = bfiq_pkg::OP_FIN3;
        dp_o.hash_clear = 1'b1;
        dp_o.res_clear  = 1'b1;
        state_d         = bfiq_pkg::ST_FIN4;
      end
      bfiq_pkg::ST_FIN4: begin
        dp_o.op        = bfiq_pkg::OP_FIN4;
        dp_o.mod_start = 1'b1;
        state_d        = bfiq_pkg::ST_MOD;
      end
      bfiq_pkg::ST_MOD: begin
        if (st_i.mod_done) begin
          state_d = bfiq_pkg::ST_PROBE;
        end
      end
      bfiq_pkg::ST_PROBE: begin
        dp_o.mem_rd = qry_q;
        dp_o.mem_wr = !qry_q;
        state_d     = bfiq_pkg::ST_RESULT;
      end
      bfiq_pkg::ST_RESULT: begin
        // read bit is back this cycle
        dp_o.res_check = qry_q;
        if (probe_last_i) begin
          res_load_o = 1'b1;
          state_d    = bfiq_pkg::ST_IDLE;
        end else begin
          dp_o.op        = bfiq_pkg::OP_STEP;
          dp_o.mod_start = 1'b1;
          state_d        = bfiq_pkg::ST_MOD;
        end
      end
      default: begin
        state_d = bfiq_pkg::ST_IDLE;
      end
    endcase
    if (state_q == bfiq_pkg::ST_IDLE && out_ready_o_i == 1'b0) begin
      out_valid_o = 1'b0;
    end
  end

  // both branches give the registered command; byte ops come only from idle, rounds after mix
  always_comb begin
    if (dp_o.op == bfiq_pkg::OP_BYTE && state_q == bfiq_pkg::ST_IDLE && has_byte_i &&
        !st_i.round_due && last_byte_i) begin
      is_query_o = qry_q;
    end else begin
      is_query_o = qry_q;
    end
  end

  `BFIQ_ASSERT_IMP(a_ready_idle, clk_i, rst_ni, in_ready_o,
    state_q == bfiq_pkg::ST_IDLE, "ready outside idle")
  `BFIQ_ASSERT_IMP(a_mem_excl, clk_i, rst_ni, dp_o.mem_rd,
    !dp_o.mem_wr && !dp_o.clr_wr, "memory read and write together")
  `BFIQ_ASSERT_NEXT(a_mod_follow, clk_i, rst_ni, dp_o.mod_start,
    state_q == bfiq_pkg::ST_MOD, "divider start not followed by wait")

endmodule

// ----- hdl/bloom_filter_insert_query.sv -----
// channel   direction  handshake                 payload
// in        input      in_valid_i / in_ready_o   cmd_i key_byte_i has_byte_i last_byte_i
// out       output     out_valid_o / out_ready_i was_query_o may_contain_o
// cfg       input      cfg_we_i                  cfg_index_i cfg_data_i
//
// one byte a cycle; a byte ending a 32-bit block runs the two-stage multiply mix and a round
// a key end runs any tail mix, the finish, then per probe the bit-serial 32-step modulo unit
// after reset the filter store is swept clear, one bit a cycle, all MAX_FILTER_BITS bits
// the output register holds one result; input is taken while it waits, until the next key end
module bloom_filter_insert_query #(
  parameter int MAX_FILTER_BITS = 65536,
  parameter int MAX_PROBES      = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        cmd_i,
  input  logic [7:0]  key_byte_i,
  input  logic        has_byte_i,
  input  logic        last_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        was_query_o,
  output logic        may_contain_o,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [16:0] cfg_data_i
);

  bfiq_pkg::cmd_t  dp_cmd;
  bfiq_pkg::stat_t dp_stat;
  logic [16:0] bit_count_q;
  logic [5:0]  probe_count_q;
  logic        probe_last, all_set, is_query, res_load;
  logic        ctrl_ready, ctrl_unused_valid;
  logic        out_valid_q;
  logic        key_end_blocked;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_count_q   <= 17'd65536;
      probe_count_q <= 6'd7;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        bfiq_pkg::RegBitCount:   bit_count_q   <= cfg_data_i;
        bfiq_pkg::RegProbeCount: probe_count_q <= cfg_data_i[5:0];
        default: begin
        end
      endcase
    end
  end

  // a key end must not start while the previous result still sits unread
  assign key_end_blocked = out_valid_q && last_byte_i;
  assign in_ready_o      = ctrl_ready && !key_end_blocked;

  bfiq_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i && !key_end_blocked),
    .in_ready_o   (ctrl_ready),
    .has_byte_i   (has_byte_i),
    .last_byte_i  (last_byte_i),
    .cmd_i        (cmd_i),
    .out_valid_o  (ctrl_unused_valid),
    .out_ready_o_i(out_ready_i),
    .dp_o         (dp_cmd),
    .st_i         (dp_stat),
    .probe_last_i (probe_last),
    .is_query_o   (is_query),
    .res_load_o   (res_load)
  );

  bfiq_datapath #(
    .MaxFilterBits(MAX_FILTER_BITS),
    .MaxProbes    (MAX_PROBES)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (dp_cmd),
    .stat_o       (dp_stat),
    .byte_i       (key_byte_i),
    .is_query_i   (is_query),
    .bit_count_i  (bit_count_q),
    .probe_count_i(probe_count_q),
    .probe_last_o (probe_last),
    .all_set_o    (all_set)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      was_query_o   <= is_query;
      may_contain_o <= all_set || ctrl_unused_valid;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ----- tb/bloom_filter_insert_query_tb.sv -----
`timescale 1ns / 100ps

module bloom_filter_insert_query_tb;

  localparam int FilterBits  = 65536;
  localparam int ProbeMax    = 32;
  // SettleCycles leaves room for a key end with 32 probes
  localparam int SettleCycles = 1500;
  // the store sweep after reset clears all FilterBits bits with nothing accepted
  localparam int StallLimit  = 200000;

  typedef struct packed {
    logic was_query;
    logic may_contain;
  } verdict_t;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic        cmd_i;
  logic [7:0]  key_byte_i;
  logic        has_byte_i;
  logic        last_byte_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic        was_query_o;
  logic        may_contain_o;
  logic        cfg_we_i;
  logic        cfg_index_i;
  logic [16:0] cfg_data_i;

  // mirror of the block: filter store, running hash and registers
  logic        bits_mirror [FilterBits];
  logic [31:0] run_hash;
  logic [31:0] blk_acc;
  logic [1:0]  blk_fill;
  logic [31:0] key_len;
  logic [16:0] bit_count_reg;
  logic [5:0]  probe_count_reg;

  verdict_t    pending_verdicts[$];
  logic [63:0] inserted_keys[$];
  int          inserted_lens[$];
  int          fail_count;
  int          beats_sent;
  bit          steady;   // no idling on either side while set

  bloom_filter_insert_query u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .cmd_i        (cmd_i),
    .key_byte_i   (key_byte_i),
    .has_byte_i   (has_byte_i),
    .last_byte_i  (last_byte_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .was_query_o  (was_query_o),
    .may_contain_o(may_contain_o),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // murmur block scramble: multiply, rotate left 15, multiply
  function automatic logic [31:0] scramble_block(input logic [31:0] k);
    logic [31:0] t;
    t = k * bfiq_pkg::MixC1;
    t = {t[16:0], t[31:17]};
    return t * bfiq_pkg::MixC2;
  endfunction

  // fold one accepted beat into the mirror, queue a verdict at a key end
  task automatic absorb_beat(input logic cmd, input logic [7:0] kb, input logic has,
                             input logic last);
    logic [31:0] x, h, stride, pos;
    int unsigned bc, np;
    logic all_set;
    if (has) begin
      blk_acc  = blk_acc | ({24'd0, kb} << (8 * blk_fill));
      blk_fill = blk_fill + 2'd1;
      key_len  = key_len + 32'd1;
      if (blk_fill == 2'd0) begin
        x        = run_hash ^ scramble_block(blk_acc);
        x        = {x[18:0], x[31:19]};
        run_hash = x * 32'd5 + bfiq_pkg::RoundAdd;
        blk_acc  = '0;
      end
    end
    if (!last) return;
    h = run_hash;
    if (blk_fill != 2'd0) h = h ^ scramble_block(blk_acc);
    h = h ^ key_len;
    h = h ^ (h >> 16);
    h = h * bfiq_pkg::FinC1;
    h = h ^ (h >> 13);
    h = h * bfiq_pkg::FinC2;
    h = h ^ (h >> 16);
    run_hash = bfiq_pkg::HashSeed;
    blk_acc  = '0;
    blk_fill = '0;
    key_len  = '0;
    // out-of-range register values are clamped at use
    bc = (bit_count_reg == 0) ? 1 : (bit_count_reg > FilterBits ? FilterBits : bit_count_reg);
    np = (probe_count_reg == 0) ? 1 : (probe_count_reg > ProbeMax ? ProbeMax : probe_count_reg);
    stride  = {h[16:0], h[31:17]};
    all_set = 1'b1;
    for (int unsigned i = 0; i < np; i++) begin
      pos = h % bc;
      if (cmd == bfiq_pkg::CmdQuery) begin
        if (!bits_mirror[pos]) all_set = 1'b0;
      end else begin
        bits_mirror[pos] = 1'b1;
      end
      h = h + stride;
    end
    pending_verdicts.push_back('{was_query: cmd,
                                 may_contain: (cmd == bfiq_pkg::CmdQuery) ? all_set : 1'b1});
  endtask

  // present one beat, hold it until taken, then maybe drop valid for a while
  task automatic send_beat(input logic cmd, input logic [7:0] kb, input logic has,
                           input logic last);
    in_valid_i  <= 1'b1;
    cmd_i       <= cmd;
    key_byte_i  <= kb;
    has_byte_i  <= has;
    last_byte_i <= last;
    do @(posedge clk_i); while (!in_ready_o);
    absorb_beat(cmd, kb, has, last);
    beats_sent++;
    if (!steady && $urandom_range(99) < 35) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
  endtask

  // one whole key, bytes in little-endian order of kbytes; noise beats may slip in
  task automatic send_key(input logic cmd, input logic [63:0] kbytes, input int len,
                          input bit noisy);
    if (len == 0) begin
      send_beat(cmd, 8'($urandom), 1'b0, 1'b1);
    end else begin
      for (int i = 0; i < len; i++) begin
        if (noisy && $urandom_range(9) == 0)
          send_beat(1'($urandom), 8'($urandom), 1'b0, 1'b0);
        // only the final beat's command matters, the others are random
        send_beat((i == len - 1) ? cmd : 1'($urandom), kbytes[8*i +: 8], 1'b1,
                  i == len - 1);
      end
    end
    if (cmd == bfiq_pkg::CmdInsert) begin
      inserted_keys.push_back(kbytes);
      inserted_lens.push_back(len);
    end
  endtask

  // wait until every verdict is in, then let the block finish any tail work
  task automatic drain;
    in_valid_i <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // both registers, back to back; only called with the block idle
  task automatic set_config(input logic [16:0] bc, input logic [16:0] np);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= bfiq_pkg::RegBitCount;
    cfg_data_i  <= bc;
    @(posedge clk_i);
    bit_count_reg = bc;
    cfg_index_i <= bfiq_pkg::RegProbeCount;
    cfg_data_i  <= np;
    @(posedge clk_i);
    probe_count_reg = np[5:0];
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [63:0] random_bytes();
    return {$urandom, $urandom};
  endfunction

  task automatic test_reset_defaults;
    // empty key, single-byte extremes, full block, block plus tail
    send_key(bfiq_pkg::CmdQuery,  64'h0, 0, 0);
    send_key(bfiq_pkg::CmdInsert, 64'h0, 0, 0);
    send_key(bfiq_pkg::CmdQuery,  64'h0, 0, 0);
    send_beat(bfiq_pkg::CmdQuery, 8'hff, 1'b0, 1'b0);            // no byte, not last: ignored
    send_key(bfiq_pkg::CmdInsert, 64'hff, 1, 0);
    send_key(bfiq_pkg::CmdQuery,  64'hff, 1, 0);
    send_key(bfiq_pkg::CmdQuery,  64'h00, 1, 0);
    send_key(bfiq_pkg::CmdInsert, 64'h0403_0201, 4, 0);
    send_key(bfiq_pkg::CmdQuery,  64'h0403_0201, 4, 0);
    send_key(bfiq_pkg::CmdQuery,  64'h05_0403_0201, 5, 0);
    // command of inner beats differs from the final one
    send_beat(bfiq_pkg::CmdQuery, 8'h5a, 1'b1, 1'b0);
    send_beat(bfiq_pkg::CmdInsert, 8'ha5, 1'b1, 1'b1);
    drain();
  endtask

  task automatic test_register_extremes;
    // zero bit count acts as one bit, oversize probe count saturates
    set_config(17'd0, 17'd63);
    send_key(bfiq_pkg::CmdQuery,  64'h77, 1, 0);
    send_key(bfiq_pkg::CmdInsert, 64'h11, 1, 0);
    send_key(bfiq_pkg::CmdQuery,  64'h99, 1, 0);
    drain();
    // oversize bit count saturates, zero probes act as one
    set_config(17'h1ffff, 17'd0);
    send_key(bfiq_pkg::CmdInsert, 64'h1234, 2, 0);
    send_key(bfiq_pkg::CmdQuery,  64'h1234, 2, 0);
    send_key(bfiq_pkg::CmdQuery,  64'h1235, 2, 0);
    drain();
    set_config(17'd1, 17'd32);
    send_key(bfiq_pkg::CmdQuery, 64'h42, 1, 0);
    drain();
    set_config(17'd65536, 17'd1);
    send_key(bfiq_pkg::CmdQuery, 64'h42, 1, 0);
    send_key(bfiq_pkg::CmdQuery, 64'h0807_0605_0403_0201, 8, 0);
    drain();
  endtask

  task automatic test_random_traffic;
    int target;
    int pick;
    int len;
    logic cmd;
    logic [16:0] bc, np;
    target = beats_sent + 1500;
    for (int phase = 0; beats_sent < target; phase++) begin
      // small filters make hits and collisions common, a few use the full store
      case ($urandom_range(3))
        0: bc = 17'($urandom_range(1, 64));
        1: bc = 17'($urandom_range(65, 4096));
        2: bc = 17'($urandom);
        default: bc = 17'd65536;
      endcase
      np = ($urandom_range(7) == 0) ? 17'($urandom) : 17'($urandom_range(1, 8));
      set_config(bc, np);
      steady = (phase == 2);
      for (int n = 0; n < 250 && beats_sent < target; ) begin
        if ($urandom_range(19) == 0) begin
          send_beat(1'($urandom), 8'($urandom), 1'b0, 1'b0);
          continue;
        end
        cmd = 1'($urandom);
        len = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 8);
        n += len + 1;
        if (cmd == bfiq_pkg::CmdQuery && inserted_keys.size() != 0 && $urandom_range(1)) begin
          pick = $urandom_range(inserted_keys.size() - 1);
          send_key(bfiq_pkg::CmdQuery, inserted_keys[pick], inserted_lens[pick], 1);
        end else begin
          send_key(cmd, random_bytes(), len, 1);
        end
      end
      steady = 1'b0;
      drain();
    end
  endtask

  // result side: ready idles at random, each beat checked against the oldest verdict
  always @(posedge clk_i) begin
    out_ready_i <= steady || ($urandom_range(99) >= 35);
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_verdicts.size() == 0) begin
        $error("unexpected result beat: was_query %0b may_contain %0b",
               was_query_o, may_contain_o);
        fail_count++;
      end else begin
        if (was_query_o !== pending_verdicts[0].was_query) begin
          $error("was_query: expected %0b actual %0b",
                 pending_verdicts[0].was_query, was_query_o);
          fail_count++;
        end
        if (may_contain_o !== pending_verdicts[0].may_contain) begin
          $error("may_contain: expected %0b actual %0b",
                 pending_verdicts[0].may_contain, may_contain_o);
          fail_count++;
        end
        void'(pending_verdicts.pop_front());
      end
    end
  end

  // watchdog on cycles without any beat on either channel
  int idle_cycles;
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > StallLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    cmd_i        = 1'b0;
    key_byte_i   = '0;
    has_byte_i   = 1'b0;
    last_byte_i  = 1'b0;
    out_ready_i  = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_index_i  = 1'b0;
    cfg_data_i   = '0;
    fail_count   = 0;
    beats_sent   = 0;
    steady       = 1'b0;
    idle_cycles  = 0;
    foreach (bits_mirror[i]) bits_mirror[i] = 1'b0;
    run_hash        = bfiq_pkg::HashSeed;
    blk_acc         = '0;
    blk_fill        = '0;
    key_len         = '0;
    bit_count_reg   = 17'd65536;
    probe_count_reg = 6'd7;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_defaults();
    test_register_extremes();
    test_random_traffic();

    if (fail_count == 0 && pending_verdicts.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
